// ===== hw/rtl/rwfc_pkg.sv =====
// Package for the ring-window FIR convolution core.
// Widths, kernel constants, state and control types shared by all modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rwfc_pkg;

   // window and kernel geometry
   localparam int WINDOW_LEN  = 16;
   localparam int KERNEL_TAPS = 5;
   localparam int NUM_OUT     = WINDOW_LEN + KERNEL_TAPS - 1;
   localparam int PTR_W       = $clog2(WINDOW_LEN);
   localparam int K_W         = $clog2(NUM_OUT);

   // field widths
   localparam int SAMPLE_W    = 12;
   localparam int COEF_W      = 16;
   localparam int PROD_W      = SAMPLE_W + COEF_W;
   localparam int VALUE_W     = 31;
   localparam int INDEX_W     = 5;
   localparam int TAP_W       = 3;
   localparam int CSR_INDEX_W = 3;

   // last tap step is the drain step of the product register
   localparam logic [TAP_W-1:0] TAP_LAST = TAP_W'(KERNEL_TAPS);

   // highest coefficient register index; anything above is ignored
   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_LAST = CSR_INDEX_W'(KERNEL_TAPS - 1);

   // coefficient reset values, Q0.16: 0.1, 0.15, 0.5, 0.15, 0.1
   localparam logic [COEF_W-1:0] COEF_RESET [KERNEL_TAPS] =
      '{16'd6554, 16'd9830, 16'd32768, 16'd9830, 16'd6554};

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_EMIT
   } state_type;

   // MAC unit control
   typedef struct packed {
      logic load_prod;
      logic clear_acc;
      logic add_acc;
   } mac_ctrl_type;

endpackage

`default_nettype wire

// ===== hw/rtl/rwfc_mac.sv =====
// Shared multiply-accumulate unit: registered product, then accumulator.
// Depends on rwfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rwfc_mac (
   input  wire logic                           clock,
   input  wire rwfc_pkg::mac_ctrl_type         ctrl,
   input  wire logic [rwfc_pkg::SAMPLE_W-1:0]  sample,
   input  wire logic [rwfc_pkg::COEF_W-1:0]    coef,
   output logic      [rwfc_pkg::VALUE_W-1:0]   acc
);
   import rwfc_pkg::*;

   logic [PROD_W-1:0]  prod_ff,  prod_in;
   logic [VALUE_W-1:0] acc_ff,   acc_in;

   // product stage
   always_comb begin
      prod_in = ctrl.load_prod ? (PROD_W'(sample) * PROD_W'(coef)) : prod_ff;
   end

   // accumulate stage
   always_comb begin
      if (ctrl.clear_acc) begin
         acc_in = '0;
      end else if (ctrl.add_acc) begin
         acc_in = acc_ff + VALUE_W'(prod_ff);
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign acc = acc_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/ring_window_fir_convolution_core.sv =====
// Top level of the ring-window FIR convolution core: sample ring, coefficient
// registers, sequencer and result register. Depends on rwfc_pkg and rwfc_mac.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   req     | req_valid, req_stall, req_sample        | in
//   rsp     | rsp_valid, rsp_stall, rsp_out_index,    | out
//           | rsp_filter_value, rsp_last              |
//   csr     | csr_write_en, csr_index, csr_wdata      | in
//
// Each request yields WINDOW_LEN + 4 results (20). Every result passes through
// 5 tap steps, one drain step and one emit step of the single shared MAC unit,
// and the emit step waits while rsp is stalled. req_stall is high whenever the
// sequencer is not idle, so a new request is accepted only after every result
// of the request before it has been emitted.
// Reset clears ring, write pointer and sequencer; coefficients get reset values.
`timescale 1ns / 1ps
`default_nettype none

module ring_window_fir_convolution_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [rwfc_pkg::SAMPLE_W-1:0]       req_sample,
   // result channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic      [rwfc_pkg::INDEX_W-1:0]        rsp_out_index,
   output logic      [rwfc_pkg::VALUE_W-1:0]        rsp_filter_value,
   output logic                                     rsp_last,
   // configuration
   input  wire logic                                csr_write_en,
   input  wire logic [rwfc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [rwfc_pkg::COEF_W-1:0]         csr_wdata
);
   import rwfc_pkg::*;

   state_type state_ff, state_in;

   logic [SAMPLE_W-1:0] ring_ff [WINDOW_LEN];
   logic [COEF_W-1:0]   coef_ff [KERNEL_TAPS];
   logic [PTR_W-1:0]    wp_ff,   wp_in;
   logic [K_W-1:0]      k_ff,    k_in;
   logic [TAP_W-1:0]    tap_ff,  tap_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0]  rsp_index_ff;
   logic [VALUE_W-1:0]  rsp_value_ff;
   logic                rsp_last_ff;

   logic                accept;
   logic                out_free;
   logic                rsp_load;
   logic                k_last;
   mac_ctrl_type        mac_ctrl;

   logic [K_W-1:0]      tap_k;
   logic [K_W-1:0]      pos;
   logic                tap_ok;
   logic [PTR_W:0]      phys_sum;
   logic [PTR_W-1:0]    phys;
   logic [SAMPLE_W-1:0] mac_sample;
   logic [COEF_W-1:0]   mac_coef;
   logic [VALUE_W-1:0]  acc;

   // common terms
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign k_last   = (k_ff == K_W'(NUM_OUT - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_MAC;
         end
         ST_MAC: begin
            if (tap_ff == TAP_LAST) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) state_in = k_last ? ST_IDLE : ST_MAC;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall          = (state_ff != ST_IDLE);
      accept             = req_valid && (state_ff == ST_IDLE);
      mac_ctrl.load_prod = (state_ff == ST_MAC) && (tap_ff < TAP_LAST);
      mac_ctrl.clear_acc = (state_ff == ST_MAC) && (tap_ff == '0);
      mac_ctrl.add_acc   = (state_ff == ST_MAC) && (tap_ff != '0);
      rsp_load           = (state_ff == ST_EMIT) && out_free;
   end

   // window position of the current tap, oldest sample at the write pointer
   always_comb begin
      tap_k    = K_W'(tap_ff);
      pos      = k_ff - tap_k;
      tap_ok   = (tap_ff < TAP_LAST) && (tap_k <= k_ff) && (pos < K_W'(WINDOW_LEN));
      phys_sum = {1'b0, wp_ff} + {1'b0, PTR_W'(pos)};
      if (phys_sum >= (PTR_W+1)'(WINDOW_LEN)) begin
         phys = PTR_W'(phys_sum - (PTR_W+1)'(WINDOW_LEN));
      end else begin
         phys = PTR_W'(phys_sum);
      end
      mac_sample = tap_ok ? ring_ff[phys] : '0;
      mac_coef   = (tap_ff < TAP_LAST) ? coef_ff[tap_ff] : '0;
   end

   rwfc_mac u_mac (
      .clock  (clock),
      .ctrl   (mac_ctrl),
      .sample (mac_sample),
      .coef   (mac_coef),
      .acc    (acc)
   );

   // counters and pointer; the tap count rests at the drain step until emitted
   always_comb begin
      wp_in  = wp_ff;
      k_in   = k_ff;
      tap_in = tap_ff;
      if (accept) begin
         wp_in  = (wp_ff == PTR_W'(WINDOW_LEN - 1)) ? '0 : wp_ff + PTR_W'(1);
         k_in   = '0;
         tap_in = '0;
      end else if ((state_ff == ST_MAC) && (tap_ff != TAP_LAST)) begin
         tap_in = tap_ff + TAP_W'(1);
      end else if (rsp_load) begin
         tap_in = '0;
         if (!k_last) k_in = k_ff + K_W'(1);
      end
   end

   // result register valid
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   // control state, ring and coefficients
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         k_ff         <= '0;
         tap_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < WINDOW_LEN; i++) ring_ff[i] <= '0;
         for (int i = 0; i < KERNEL_TAPS; i++) coef_ff[i] <= COEF_RESET[i];
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         k_ff         <= k_in;
         tap_ff       <= tap_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) ring_ff[wp_ff] <= req_sample;
         if (csr_write_en && (csr_index <= CSR_COEF_LAST)) coef_ff[csr_index] <= csr_wdata;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_index_ff <= INDEX_W'(k_ff);
         rsp_value_ff <= acc;
         rsp_last_ff  <= k_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_index    = rsp_index_ff;
   assign rsp_filter_value = rsp_value_ff;
   assign rsp_last         = rsp_last_ff;

   // checks
   a_accept_starts_run: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_MAC) && (k_ff == '0) && (tap_ff == '0))
      else $error("request did not start a run at k = 0");

   a_tap_bound: assert property (@(posedge clock) disable iff (reset)
      tap_ff <= TAP_LAST)
      else $error("tap step beyond drain step");

   a_wp_bound: assert property (@(posedge clock) disable iff (reset)
      wp_ff < PTR_W'(WINDOW_LEN - 1) || wp_ff == PTR_W'(WINDOW_LEN - 1))
      else $error("write pointer outside the window");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> rsp_index_ff == INDEX_W'(NUM_OUT - 1))
      else $error("last flag on wrong result position");

   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff)
      else $error("emitted result not presented");

endmodule

`default_nettype wire

// ===== tb/tb_ring_window_fir_convolution_core.sv =====
// Testbench for ring_window_fir_convolution_core: feeds ADC samples and kernel
// writes, predicts all twenty convolution outputs per request and checks them.
// Depends on rwfc_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_ring_window_fir_convolution_core;
   import rwfc_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 4 * (KERNEL_TAPS + 2);
   localparam int RANDOM_PHASES  = 10;
   localparam int PHASE_REQUESTS = 45;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;
   localparam logic [COEF_W-1:0]   COEF_MAX   = '1;

   typedef logic [KERNEL_TAPS-1:0][COEF_W-1:0] kernel_set_t;

   typedef struct {
      logic [INDEX_W-1:0] out_index;
      logic [VALUE_W-1:0] filter_value;
      logic               last;
   } conv_point_t;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [SAMPLE_W-1:0]    req_sample;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [INDEX_W-1:0]     rsp_out_index;
   logic [VALUE_W-1:0]     rsp_filter_value;
   logic                   rsp_last;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [COEF_W-1:0]      csr_wdata;

   // predictor state: sample window, write slot and kernel taps
   logic [SAMPLE_W-1:0] sample_window [WINDOW_LEN];
   int unsigned         write_slot;
   logic [COEF_W-1:0]   kernel_taps [KERNEL_TAPS];
   conv_point_t         pending_points [$];

   int error_count;
   int idle_cycles;
   int stall_left;
   bit calm;

   ring_window_fir_convolution_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_index    (rsp_out_index),
      .rsp_filter_value (rsp_filter_value),
      .rsp_last         (rsp_last),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // store the new sample, then form the full convolution, oldest sample first
   task automatic predict_convolution(input logic [SAMPLE_W-1:0] value);
      logic [63:0] acc;
      int unsigned pos;
      conv_point_t point;
      sample_window[write_slot] = value;
      write_slot = (write_slot + 1) % WINDOW_LEN;
      for (int k = 0; k < NUM_OUT; k++) begin
         acc = 64'd0;
         for (int tap = 0; tap < KERNEL_TAPS && tap <= k; tap++) begin
            pos = k - tap;
            if (pos < WINDOW_LEN)
               acc = acc + 64'(sample_window[(write_slot + pos) % WINDOW_LEN])
                         * 64'(kernel_taps[tap]);
         end
         point.out_index    = INDEX_W'(k);
         point.filter_value = acc[VALUE_W-1:0];
         point.last         = (k == NUM_OUT - 1);
         pending_points.push_back(point);
      end
   endtask

   // one request: random gap, then hold until accepted; valid stays up afterwards
   task automatic send_sample(input logic [SAMPLE_W-1:0] value);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= value;
      do @(posedge clock); while (req_stall);
      predict_convolution(value);
   endtask

   // drop valid and let every outstanding output arrive
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
   endtask

   // burst of coefficient writes, optionally followed by writes to unused indexes
   task automatic program_kernel(input kernel_set_t taps, input bit poke_unused,
                                 input logic [COEF_W-1:0] junk);
      for (int tap = 0; tap < KERNEL_TAPS; tap++) begin
         csr_write_en <= 1'b1;
         csr_index    <= CSR_INDEX_W'(tap);
         csr_wdata    <= taps[tap];
         @(posedge clock);
         kernel_taps[tap] = taps[tap];
      end
      if (poke_unused) begin
         for (int idx = int'(CSR_COEF_LAST) + 1; idx < 2 ** CSR_INDEX_W; idx++) begin
            csr_write_en <= 1'b1;
            csr_index    <= CSR_INDEX_W'(idx);
            csr_wdata    <= junk;
            @(posedge clock);
         end
      end
      csr_write_en <= 1'b0;
   endtask

   function automatic logic [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return SAMPLE_MAX;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic kernel_set_t uniform_kernel(input logic [COEF_W-1:0] c);
      kernel_set_t taps;
      for (int tap = 0; tap < KERNEL_TAPS; tap++)
         taps[tap] = c;
      return taps;
   endfunction

   function automatic kernel_set_t reset_kernel();
      kernel_set_t taps;
      for (int tap = 0; tap < KERNEL_TAPS; tap++)
         taps[tap] = COEF_RESET[tap];
      return taps;
   endfunction

   // full-scale sample, then a sample of one, into an otherwise cleared ring, reset kernel
   task automatic test_fresh_ring();
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_W'(1));
      wait_until_drained();
   endtask

   // full-scale kernel over a full-scale window gives the largest sum; then zero kernel
   task automatic test_extreme_kernel();
      program_kernel(uniform_kernel(COEF_MAX), 1'b0, '0);
      for (int n = 0; n < WINDOW_LEN; n++)
         send_sample(SAMPLE_MAX);
      wait_until_drained();
      program_kernel(uniform_kernel('0), 1'b0, '0);
      send_sample(SAMPLE_MAX);
      wait_until_drained();
   endtask

   // writes above the last coefficient must leave the kernel alone
   task automatic test_unused_registers();
      program_kernel(reset_kernel(), 1'b1, COEF_MAX);
      program_kernel(reset_kernel(), 1'b1, '0);
      send_sample(SAMPLE_W'(12'h800));
      send_sample(SAMPLE_W'(12'h7FF));
      wait_until_drained();
   endtask

   // distinct taps so that a swapped or shifted tap shows up
   task automatic test_distinct_taps();
      kernel_set_t taps;
      taps[0] = COEF_W'(1);
      taps[1] = COEF_W'(16'h8000);
      taps[2] = '0;
      taps[3] = COEF_W'(16'hAAAA);
      taps[4] = COEF_W'(16'h5555);
      program_kernel(taps, 1'b0, '0);
      send_sample(SAMPLE_W'(1));
      send_sample('0);
      send_sample(SAMPLE_W'(12'hA5A));
      wait_until_drained();
   endtask

   // random sample streams over a spread of kernels, with calm stretches
   task automatic test_random_stream();
      kernel_set_t taps;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase % 5)
            0: taps = uniform_kernel(COEF_MAX);
            1: taps = reset_kernel();
            2: for (int tap = 0; tap < KERNEL_TAPS; tap++) taps[tap] = COEF_W'($urandom);
            3: begin
               taps = uniform_kernel('0);
               taps[$urandom_range(0, KERNEL_TAPS - 1)] = COEF_W'($urandom);
            end
            default:
               for (int tap = 0; tap < KERNEL_TAPS; tap++)
                  case ($urandom_range(0, 2))
                     0:       taps[tap] = '0;
                     1:       taps[tap] = COEF_MAX;
                     default: taps[tap] = COEF_W'($urandom);
                  endcase
         endcase
         program_kernel(taps, $urandom_range(0, 1), COEF_W'($urandom));
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            if (n % 15 == 0)
               calm = ($urandom_range(0, 3) == 0);
            // occasionally hold off until the core has delivered everything
            if (n != 0 && $urandom_range(0, 39) == 0)
               wait_until_drained();
            send_sample(random_sample());
         end
         wait_until_drained();
      end
      calm = 1'b0;
   endtask

   // output stall: random stall after each accepted output, counted down while valid
   always @(posedge clock) begin
      if (reset) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            stall_left = calm ? 0 : $urandom_range(0, 7);
         else if (rsp_valid && stall_left != 0)
            stall_left = stall_left - 1;
         rsp_stall <= (stall_left != 0);
      end
   end

   task automatic check_field(input string name, input logic [VALUE_W-1:0] expected,
                              input logic [VALUE_W-1:0] actual);
      if (actual !== expected) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expected, actual);
      end
   endtask

   // compare every accepted output with the oldest prediction
   always @(posedge clock) begin
      conv_point_t point;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_points.size() == 0) begin
            error_count++;
            $display("%0t: unexpected output, expected none, actual index %0d value %0d last %0b",
                     $time, rsp_out_index, rsp_filter_value, rsp_last);
         end else begin
            point = pending_points.pop_front();
            check_field("out_index", VALUE_W'(point.out_index), VALUE_W'(rsp_out_index));
            check_field("filter_value", point.filter_value, rsp_filter_value);
            check_field("last", VALUE_W'(point.last), VALUE_W'(rsp_last));
         end
      end
   end

   // watchdog on cycles with no handshake and no register write
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_en)
         idle_cycles = 0;
      else begin
         idle_cycles = idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired with %0d outputs outstanding",
                     $time, pending_points.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   initial begin
      error_count = 0;
      idle_cycles = 0;
      calm        = 1'b0;
      write_slot  = 0;
      for (int n = 0; n < WINDOW_LEN; n++)
         sample_window[n] = '0;
      for (int tap = 0; tap < KERNEL_TAPS; tap++)
         kernel_taps[tap] = COEF_RESET[tap];
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_sample   <= '0;
      rsp_stall    <= 1'b0;
      csr_write_en <= 1'b0;
      csr_index    <= '0;
      csr_wdata    <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_fresh_ring();
      test_extreme_kernel();
      test_unused_registers();
      test_distinct_taps();
      test_random_stream();

      wait_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
